FILE: hdl/lfia_pkg.sv
// Lowest-free ID allocator: shared types, constants and the chunk priority encoder.
// No dependencies; used by lowest_free_id_allocator_top.
`default_nettype none
package lfia_pkg;

	localparam int ID_W        = 8;
	localparam int TAG_W       = 16;
	localparam int SLOT_COUNT  = 256;
	localparam int CHUNK_W     = 32;
	localparam int CHUNK_N     = SLOT_COUNT / CHUNK_W;
	localparam int CHUNK_IDX_W = $clog2(CHUNK_N);
	localparam int BIT_IDX_W   = $clog2(CHUNK_W);
	localparam int CFG_IDX_W   = 2;

	typedef logic [ID_W-1:0]        id_t;
	typedef logic [TAG_W-1:0]       tag_t;
	typedef logic [CHUNK_W-1:0]     chunk_t;
	typedef logic [CHUNK_IDX_W-1:0] chunk_idx_t;
	typedef logic [BIT_IDX_W-1:0]   bit_idx_t;

	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_RELEASE = 2'd1,
		REQ_LOOKUP  = 2'd2,
		REQ_NOP     = 2'd3
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RANGE_LOW  = 2'd0,
		CFG_RANGE_HIGH = 2'd1,
		CFG_TRANSLATE  = 2'd2,
		CFG_UNUSED     = 2'd3
	} cfg_idx_t;

	localparam id_t RESET_RANGE_LOW  = 8'd1;
	localparam id_t RESET_RANGE_HIGH = 8'd254;

	function automatic bit_idx_t lowest_set(input chunk_t v);
		bit_idx_t idx;
		idx = '0;
		for (int i = CHUNK_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = bit_idx_t'(i);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/lowest_free_id_allocator_top.sv
// Lowest-free ID allocator: busy map, owner tag store and scan sequencer.
// Depends on lfia_pkg.
//
// Usage: pulse start with req_type, slot_id and owner_tag while busy is low; the beat
// is taken at that edge. Exactly one result beat follows, shown for one cycle with done
// high on granted_id, found and owner_out. The receiver cannot hold it off.
// Allocate walks the 256-entry busy map in 32-slot chunks through one shared range
// mask and priority encoder, one chunk a cycle, until a free slot or the last chunk.
// Release and no-operation go straight to the result; lookup adds a registered tag read.
// busy stays high until the result cycle has ended, so one request is in flight.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; write only
// while busy is low. Indexes beyond the register list are dropped.
// Reset: all slots free, range 1..254, translate mode on. The tag store has no reset;
// it is only read for busy slots, which were written by their allocation.
`default_nettype none
module lowest_free_id_allocator_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [1:0]                          req_type,
	input  wire logic [lfia_pkg::ID_W-1:0]           slot_id,
	input  wire logic [lfia_pkg::TAG_W-1:0]          owner_tag,
	input  wire logic                                cfg_we,
	input  wire logic [lfia_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [lfia_pkg::ID_W-1:0]           cfg_data,
	output logic                                     done,
	output logic [lfia_pkg::ID_W-1:0]                granted_id,
	output logic                                     found,
	output logic [lfia_pkg::TAG_W-1:0]               owner_out
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_READ = 4'b0100,
		ST_RESP = 4'b1000
	} state_t;

	state_t                           state_q;
	logic [lfia_pkg::SLOT_COUNT-1:0]  busy_map_q;
	lfia_pkg::tag_t                   owner_mem [lfia_pkg::SLOT_COUNT];
	lfia_pkg::tag_t                   rd_data_q;
	lfia_pkg::id_t                    range_low_q;
	lfia_pkg::id_t                    range_high_q;
	logic                             translate_q;
	lfia_pkg::chunk_idx_t             chunk_q;
	lfia_pkg::tag_t                   tag_q;
	lfia_pkg::id_t                    granted_q;
	logic                             found_q;
	lfia_pkg::tag_t                   owner_q;

	logic                             accept;
	lfia_pkg::req_t                   req;
	lfia_pkg::id_t                    lookup_id;
	logic                             lookup_hit;
	logic                             sid_in_range;
	lfia_pkg::chunk_t                 busy_chunk;
	lfia_pkg::chunk_t                 free_mask;
	lfia_pkg::bit_idx_t               free_bit;
	lfia_pkg::id_t                    free_id;
	logic                             scan_hit;
	logic                             mem_we;

	assign accept = start && !busy;
	assign req    = lfia_pkg::req_t'(req_type);
	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_RESP);

	assign lookup_id    = translate_q ? slot_id : range_low_q;
	assign lookup_hit   = (lookup_id >= range_low_q) && (lookup_id <= range_high_q)
		&& busy_map_q[lookup_id];
	assign sid_in_range = (slot_id >= range_low_q) && (slot_id <= range_high_q);

	assign busy_chunk = busy_map_q[chunk_q * lfia_pkg::CHUNK_W +: lfia_pkg::CHUNK_W];

	always_comb begin
		lfia_pkg::id_t cand;
		for (int i = 0; i < lfia_pkg::CHUNK_W; i++) begin
			cand = {chunk_q, lfia_pkg::bit_idx_t'(i)};
			free_mask[i] = (cand >= range_low_q) && (cand <= range_high_q) && !busy_chunk[i];
		end
	end

	assign free_bit = lfia_pkg::lowest_set(free_mask);
	assign free_id  = {chunk_q, free_bit};
	assign scan_hit = |free_mask;
	assign mem_we   = (state_q == ST_SCAN) && scan_hit;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			owner_mem[free_id] <= tag_q;
		end
		rd_data_q <= owner_mem[lookup_id];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= lfia_pkg::RESET_RANGE_LOW;
			range_high_q <= lfia_pkg::RESET_RANGE_HIGH;
			translate_q  <= 1'b1;
		end else if (cfg_we) begin
			case (lfia_pkg::cfg_idx_t'(cfg_index))
				lfia_pkg::CFG_RANGE_LOW:  range_low_q  <= cfg_data;
				lfia_pkg::CFG_RANGE_HIGH: range_high_q <= cfg_data;
				lfia_pkg::CFG_TRANSLATE:  translate_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			busy_map_q <= '0;
			chunk_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req)
							lfia_pkg::REQ_ALLOC: begin
								chunk_q <= '0;
								state_q <= ST_SCAN;
							end
							lfia_pkg::REQ_RELEASE: begin
								if (sid_in_range) begin
									busy_map_q[slot_id] <= 1'b0;
								end
								state_q <= ST_RESP;
							end
							lfia_pkg::REQ_LOOKUP: begin
								state_q <= ST_READ;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_hit) begin
						busy_map_q[free_id] <= 1'b1;
						state_q             <= ST_RESP;
					end else if (chunk_q == lfia_pkg::chunk_idx_t'(lfia_pkg::CHUNK_N - 1)) begin
						state_q <= ST_RESP;
					end else begin
						chunk_q <= chunk_q + 1'b1;
					end
				end
				ST_READ: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					tag_q     <= owner_tag;
					granted_q <= slot_id;
					found_q   <= 1'b0;
					owner_q   <= '0;
					if (req == lfia_pkg::REQ_ALLOC) begin
						granted_q <= '0;
					end else if (req == lfia_pkg::REQ_LOOKUP) begin
						granted_q <= lookup_id;
						found_q   <= lookup_hit;
					end
				end
			end
			ST_SCAN: begin
				if (scan_hit) begin
					granted_q <= free_id;
					found_q   <= 1'b1;
					owner_q   <= tag_q;
				end
			end
			ST_READ: begin
				owner_q <= found_q ? rd_data_q : '0;
			end
			default: ;
		endcase
	end

	assign granted_id = granted_q;
	assign found      = found_q;
	assign owner_out  = owner_q;

endmodule
`default_nettype wire
